>>> src/lfsta_pkg.sv
// Shared types for the lowest-free-slot timed allocator.
// Used by lfsta_slot_unit and lowest_free_slot_timed_allocator_core; no dependencies.
package lfsta_pkg;

    localparam int TIME_W   = 32;
    localparam int COUNT_W  = 32;
    localparam int ACTIVE_W = 7;
    localparam int INDEX_W  = 6;

    // One slot record as kept in the slot memory
    typedef struct packed {
        logic               used;
        logic [TIME_W-1:0]  busy_until;
        logic [COUNT_W-1:0] served;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Verdict of the slot unit on one record
    typedef struct packed {
        logic   wr_en;   // record changes and must be written back
        logic   take;    // this slot is granted to the request
        t_entry wr_data; // updated record
    } t_slot_eval;

endpackage

>>> src/lowest_free_slot_timed_allocator_core.sv
// Result: an accepted word is answered after one scan pass over the slot memory, one
// read per cycle through its single read port; the result is then registered.
// A new word is taken only once the result of the last is in the output register; a
// word with tlast set adds a clearing pass before the next word is taken.
// Reset: synchronous, active low; a clearing pass follows, during
// which no word is taken. active_slots resets to 64; config writes are taken only while
// idle or clearing, and a pending config write holds off the request stream.
// Depends on lfsta_pkg, lfsta_ram and lfsta_slot_unit.
module lowest_free_slot_timed_allocator_core #(
    parameter int MAX_SLOTS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // start_time [31:0], end_time [63:32]
    input  logic        s_axis_tlast,   // last_in_set
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // slot_index [5:0], slot_served [37:6], zero [39:38]
    output logic        m_axis_tuser,   // granted
    // Configuration: active_slots
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_cfg_data
);
    import lfsta_pkg::*;

    localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam int LW = (CW > ACTIVE_W) ? CW : ACTIVE_W;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]          r_state;
    logic [CW-1:0]       r_cnt;
    logic                r_ev_valid;
    logic                r_ev_last;
    logic [AW-1:0]       r_ev_idx;
    logic [TIME_W-1:0]   r_start;
    logic [TIME_W-1:0]   r_stop;
    logic                r_last;
    logic                r_found;
    logic [AW-1:0]       r_pick;
    logic [COUNT_W-1:0]  r_served;
    logic [ACTIVE_W-1:0] r_active;
    logic                r_out_valid;
    logic                r_out_granted;
    logic [INDEX_W-1:0]  r_out_index;
    logic [COUNT_W-1:0]  r_out_served;

    logic [LW-1:0]       w_limit;
    logic                w_issue;
    logic                w_out_load;
    logic                w_wr_en;
    logic [AW-1:0]       w_wr_addr;
    t_entry              w_wr_data;
    t_entry              w_rd_entry;
    logic [ENTRY_W-1:0]  w_rd_bits;
    t_slot_eval          w_eval;

    // Clamp active count to the number of slots
    assign w_limit = (LW'(r_active) > LW'(MAX_SLOTS)) ? LW'(MAX_SLOTS) : LW'(r_active);

    // Take config only between requests; a config word goes ahead of a request word
    assign s_axis_tready = (r_state == ST_IDLE) && !i_cfg_valid;
    assign o_cfg_ready   = (r_state == ST_IDLE) || (r_state == ST_CLEAR);
    assign w_issue       = (r_state == ST_SCAN) && (r_cnt != CW'(MAX_SLOTS));
    assign w_out_load    = (r_state == ST_EMIT) && (!r_out_valid || m_axis_tready);
    assign w_rd_entry    = t_entry'(w_rd_bits);

    lfsta_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_SLOTS)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_issue),
        .i_rd_addr (r_cnt[AW-1:0]),
        .o_rd_data (w_rd_bits)
    );

    lfsta_slot_unit u_slot_unit (
        .i_entry    (w_rd_entry),
        .i_start    (r_start),
        .i_stop     (r_stop),
        .i_in_range (LW'(r_ev_idx) < w_limit),
        .i_found    (r_found),
        .o_eval     (w_eval)
    );

    // Write port: zeros while clearing, else write back the evaluated record
    always_comb begin
        if (r_state == ST_CLEAR) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_cnt[AW-1:0];
            w_wr_data = '0;
        end else begin
            w_wr_en   = r_ev_valid && w_eval.wr_en;
            w_wr_addr = r_ev_idx;
            w_wr_data = w_eval.wr_data;
        end
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= ACTIVE_W'(64);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_active <= i_cfg_data;
        end
    end

    // Sequencer: clear, wait, scan, emit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_cnt      <= '0;
            r_ev_valid <= 1'b0;
            r_ev_last  <= 1'b0;
            r_found    <= 1'b0;
        end else begin
            unique case (r_state)
                ST_CLEAR: begin
                    if (r_cnt == CW'(MAX_SLOTS - 1)) begin
                        r_state <= ST_IDLE;
                        r_cnt   <= '0;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_state <= ST_SCAN;
                        r_cnt   <= '0;
                        r_found <= 1'b0;
                    end
                end
                ST_SCAN: begin
                    // Issue one read per cycle
                    r_ev_valid <= w_issue;
                    if (w_issue) begin
                        r_ev_last <= (r_cnt == CW'(MAX_SLOTS - 1));
                        r_ev_idx  <= r_cnt[AW-1:0];
                        r_cnt     <= r_cnt + 1'b1;
                    end
                    // Evaluate the record read last cycle
                    if (r_ev_valid) begin
                        if (w_eval.take) begin
                            r_found <= 1'b1;
                        end
                        if (r_ev_last) begin
                            r_state <= ST_EMIT;
                        end
                    end
                end
                ST_EMIT: begin
                    r_ev_valid <= 1'b0;
                    if (w_out_load) begin
                        r_state <= r_last ? ST_CLEAR : ST_IDLE;
                        r_cnt   <= '0;
                    end
                end
                default: begin
                    r_state <= ST_CLEAR;
                    r_cnt   <= '0;
                end
            endcase
        end
    end

    // Request and pick payload
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_start <= s_axis_tdata[31:0];
            r_stop  <= s_axis_tdata[63:32];
            r_last  <= s_axis_tlast;
        end
        if ((r_state == ST_SCAN) && r_ev_valid && w_eval.take) begin
            r_pick   <= r_ev_idx;
            r_served <= w_eval.wr_data.served;
        end
    end

    // Output register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_granted <= r_found;
            r_out_index   <= r_found ? INDEX_W'(r_pick) : '0;
            r_out_served  <= r_found ? r_served : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_granted;
    assign m_axis_tdata  = {2'b00, r_out_served, r_out_index};

`ifndef SYNTH
    // Input is closed on the cycle after a word is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input still ready after accepting a word");

    // A new result appears only out of the emit state
    a_result_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !$past(m_axis_tvalid)) |-> $past(r_state == ST_EMIT))
        else $error("result appeared outside the emit state");

    // A grant always names a slot within the active range
    a_pick_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && r_found) |-> (LW'(r_pick) < w_limit))
        else $error("granted slot beyond the active count");

    // A granted slot has a nonzero served count
    a_grant_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[37:6] != '0))
        else $error("granted slot reports a zero served count");
`endif

endmodule

>>> src/lfsta_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module lfsta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

>>> src/lfsta_slot_unit.sv
// Shared slot evaluator: release test, free test and served-count update.
// Depends on lfsta_pkg.
module lfsta_slot_unit (
    input  lfsta_pkg::t_entry             i_entry,
    input  logic [lfsta_pkg::TIME_W-1:0]  i_start,
    input  logic [lfsta_pkg::TIME_W-1:0]  i_stop,
    input  logic                          i_in_range,
    input  logic                          i_found,
    output lfsta_pkg::t_slot_eval         o_eval
);
    import lfsta_pkg::*;

    logic release_hit;
    logic used_now;

    // Release a used slot whose busy time has passed
    assign release_hit = i_entry.used && (i_entry.busy_until <= i_start);
    assign used_now    = i_entry.used && !release_hit;

    always_comb begin
        o_eval.take    = !used_now && i_in_range && !i_found;
        o_eval.wr_en   = o_eval.take || release_hit;
        o_eval.wr_data = i_entry;
        if (o_eval.take) begin
            o_eval.wr_data.used       = 1'b1;
            o_eval.wr_data.busy_until = i_stop;
            if (i_entry.served != {COUNT_W{1'b1}}) begin
                o_eval.wr_data.served = i_entry.served + 1'b1;
            end
        end else begin
            o_eval.wr_data.used = used_now;
        end
    end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// Testbench for lowest_free_slot_timed_allocator_core: random and directed requests checked
// against a slot-table predictor. Depends on lfsta_pkg and the core RTL.
module tb;

    import lfsta_pkg::TIME_W;
    import lfsta_pkg::COUNT_W;
    import lfsta_pkg::INDEX_W;
    import lfsta_pkg::ACTIVE_W;

    localparam int N_SLOTS      = 64;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_CYCLES  = 600;
    localparam int SETTLE_TAIL  = 2 * N_SLOTS + 8;
    localparam int N_PHASES     = 10;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    typedef struct packed {
        logic [TIME_W-1:0] start_t;
        logic [TIME_W-1:0] stop_t;
        logic              last;
    } t_req;

    typedef struct packed {
        logic               granted;
        logic [INDEX_W-1:0] slot;
        logic [COUNT_W-1:0] served;
    } t_grant;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata  = '0;    // start_time [31:0], end_time [63:32]
    logic        s_axis_tlast  = 1'b0;  // last_in_set
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;          // slot_index [5:0], slot_served [37:6], zero [39:38]
    logic        m_axis_tuser;          // granted
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [6:0]  i_cfg_data    = '0;

    // Predictor state: mirrors the slot table and the active-slot register
    logic [TIME_W-1:0]   slot_until  [N_SLOTS];
    bit                  slot_busy   [N_SLOTS];
    bit [COUNT_W-1:0]    slot_served [N_SLOTS];
    logic [ACTIVE_W-1:0] active_cfg = 7'd64;

    t_req   pending_reqs [$];
    t_grant grant_q      [$];
    int     req_offered = 0;
    int     req_taken   = 0;
    int     errors      = 0;
    int     cycle_cnt   = 0;
    bit     no_idle     = 1'b0;
    int     hold_req    = 0;

    lowest_free_slot_timed_allocator_core #(
        .MAX_SLOTS(N_SLOTS)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Release expired slots, grant the lowest free active one, clear on last in set
    function automatic t_grant allocate_slot(input logic [TIME_W-1:0] t_start,
                                             input logic [TIME_W-1:0] t_stop,
                                             input logic last);
        t_grant g;
        int     lim;
        int     pick;
        g    = '0;
        pick = -1;
        lim  = (active_cfg > N_SLOTS) ? N_SLOTS : int'(active_cfg);
        for (int k = 0; k < N_SLOTS; k++) begin
            if (slot_busy[k] && slot_until[k] <= t_start)
                slot_busy[k] = 1'b0;
        end
        for (int k = 0; k < lim && pick < 0; k++) begin
            if (!slot_busy[k])
                pick = k;
        end
        if (pick >= 0) begin
            slot_busy[pick]  = 1'b1;
            slot_until[pick] = t_stop;
            if (slot_served[pick] != '1)
                slot_served[pick]++;
            g.granted = 1'b1;
            g.slot    = INDEX_W'(pick);
            g.served  = slot_served[pick];
        end
        if (last) begin
            for (int k = 0; k < N_SLOTS; k++) begin
                slot_busy[k]   = 1'b0;
                slot_until[k]  = '0;
                slot_served[k] = '0;
            end
        end
        return g;
    endfunction

    // Request driver: hold the word until taken, then offer the next or idle
    always @(negedge i_clk) begin : req_driver
        int   gap_left;
        t_req cur;
        if (i_rst_n && (!s_axis_tvalid || req_taken == req_offered)) begin
            if (gap_left != 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 7) == 0) begin
                gap_left = $urandom_range(0, 8);
                s_axis_tvalid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
                cur = pending_reqs.pop_front();
                s_axis_tdata  <= {cur.stop_t, cur.start_t};
                s_axis_tlast  <= cur.last;
                s_axis_tvalid <= 1'b1;
                req_offered++;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver: long hold-off on request, short random stalls otherwise
    always @(negedge i_clk) begin : res_receiver
        int hold_left;
        int hold_done;
        int stall_left;
        if (hold_done != hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_done = hold_req;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 8);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Monitor: predict on each accepted request, compare each accepted result
    always @(posedge i_clk) begin : monitor
        t_grant want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                req_taken++;
                grant_q.push_back(allocate_slot(s_axis_tdata[31:0], s_axis_tdata[63:32],
                                                s_axis_tlast));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (grant_q.size() == 0) begin
                    $error("result word with no request pending: granted %0d slot %0d",
                           m_axis_tuser, m_axis_tdata[5:0]);
                    errors++;
                end else begin
                    want = grant_q.pop_front();
                    if (m_axis_tuser !== want.granted) begin
                        $error("granted: expected %0d, actual %0d", want.granted,
                               m_axis_tuser);
                        errors++;
                    end
                    if (m_axis_tdata[5:0] !== want.slot) begin
                        $error("slot_index: expected %0d, actual %0d", want.slot,
                               m_axis_tdata[5:0]);
                        errors++;
                    end
                    if (m_axis_tdata[37:6] !== want.served) begin
                        $error("slot_served: expected %0d, actual %0d", want.served,
                               m_axis_tdata[37:6]);
                        errors++;
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic add_req(input logic [TIME_W-1:0] t_start, input logic [TIME_W-1:0] t_stop,
                           input logic last);
        t_req r;
        r.start_t = t_start;
        r.stop_t  = t_stop;
        r.last    = last;
        pending_reqs.push_back(r);
    endtask

    // Wait until every request is taken and answered, then let the block finish clearing
    task automatic settle();
        while (pending_reqs.size() != 0 || req_taken != req_offered || grant_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_TAIL) @(posedge i_clk);
    endtask

    task automatic write_active(input logic [ACTIVE_W-1:0] value);
        @(negedge i_clk);
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        active_cfg = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Random request sets: mostly ordered sets with light or heavy load, some wild or noisy
    task automatic queue_random_sets(input int count);
        longint t;
        longint stop_v;
        int     len;
        int     mode;
        while (count > 0) begin
            mode = $urandom_range(0, 9);
            len  = (mode >= 5 && mode <= 7) ? $urandom_range(40, 90) : $urandom_range(1, 30);
            if (len > count)
                len = count;
            case ($urandom_range(0, 3))
                0:       t = 0;
                1:       t = $urandom;
                2:       t = 64'hFFFF_F000 + $urandom_range(0, 'hF00);
                default: t = $urandom_range(0, 5000);
            endcase
            for (int k = 0; k < len; k++) begin
                if (mode <= 4) begin
                    t      = t + $urandom_range(0, 30);
                    stop_v = t + $urandom_range(0, 60);
                end else if (mode <= 7) begin
                    t      = t + $urandom_range(0, 8);
                    stop_v = t + $urandom_range(50, 4000);
                end else if (mode == 8) begin
                    t      = t + $urandom_range(0, 100000);
                    stop_v = $urandom;
                end else begin
                    // step start back now and then, end before start
                    if ($urandom_range(0, 2) == 0)
                        t = t - $urandom_range(0, 50);
                    else
                        t = t + $urandom_range(0, 20);
                    if (t < 0)
                        t = 0;
                    stop_v = t - $urandom_range(0, 20);
                    if (stop_v < 0)
                        stop_v = 0;
                end
                if (t > TIME_MAX)
                    t = TIME_MAX;
                if (stop_v > TIME_MAX)
                    stop_v = TIME_MAX;
                add_req(t[TIME_W-1:0], stop_v[TIME_W-1:0], k == len - 1);
            end
            count -= len;
        end
    endtask

    initial begin
        logic [ACTIVE_W-1:0] phase_active [N_PHASES];
        int                  phase_items  [N_PHASES];
        phase_active = '{7'd127, 7'd1, 7'd64, 7'd2, 7'd0, 7'd13, 7'd65, 7'd64, 7'd31, 7'd64};
        phase_items  = '{60, 50, 120, 50, 20, 60, 70, 100, 60, 110};
        phase_active[8] = ACTIVE_W'($urandom_range(3, 63));
        for (int k = 0; k < N_SLOTS; k++) begin
            slot_until[k] = '0;
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset setting: end before start, out-of-order start, extremes, clear on last
        add_req(32'h0, 32'hFFFF_FFFF, 1'b0);
        add_req(32'h0, 32'hFFFF_FFFF, 1'b0);
        add_req(32'd5, 32'd3, 1'b0);
        add_req(32'd5, 32'd100, 1'b0);
        add_req(32'd4, 32'd10, 1'b0);
        add_req(32'd100, 32'd200, 1'b0);
        add_req(32'd50, 32'd60, 1'b0);
        add_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        add_req(32'h0, 32'h0, 1'b1);
        settle();

        // One slot: busy rejects, release exactly at the end time
        write_active(7'd1);
        add_req(32'd10, 32'd20, 1'b0);
        add_req(32'd15, 32'd30, 1'b0);
        add_req(32'd20, 32'd25, 1'b0);
        add_req(32'd21, 32'd0, 1'b1);
        settle();

        // No slots: every request rejected
        write_active(7'd0);
        add_req(32'h0, 32'h0, 1'b0);
        add_req(32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
        settle();

        // Occupy four slots, then shrink the active count below them
        write_active(7'd64);
        for (int k = 0; k < 4; k++)
            add_req(k, 32'd1000, 1'b0);
        settle();
        write_active(7'd2);
        add_req(32'd999, 32'd5, 1'b0);
        add_req(32'd1000, 32'd7, 1'b0);
        add_req(32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
        settle();

        // Random phases across settings; long receiver hold-off in one, no idling in the last
        for (int p = 0; p < N_PHASES; p++) begin
            write_active(phase_active[p]);
            if (p == N_PHASES - 1)
                no_idle = 1'b1;
            queue_random_sets(phase_items[p]);
            if (p == 2)
                hold_req++;
            settle();
        end

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
